@@ rtl/core/sfvg_pkg.sv @@
`timescale 1ns / 1ps
// shared types, segment table and character map for the vector character generator
package sfvg_pkg;

    localparam int TABLE_LEN  = 23;
    localparam int SEG_IDX_W  = 5;
    localparam int TCOORD_W   = 11;
    localparam int PROD_W     = 27;
    localparam int COORD_W    = 20;
    localparam int PEN_X_W    = 22;
    localparam int SIZE_W     = 16;

    localparam logic [TABLE_LEN-1:0] SG_TOPL   = 23'h000001;
    localparam logic [TABLE_LEN-1:0] SG_TOPR   = 23'h000002;
    localparam logic [TABLE_LEN-1:0] SG_UPR    = 23'h000004;
    localparam logic [TABLE_LEN-1:0] SG_LOR    = 23'h000008;
    localparam logic [TABLE_LEN-1:0] SG_BOTR   = 23'h000010;
    localparam logic [TABLE_LEN-1:0] SG_BOTL   = 23'h000020;
    localparam logic [TABLE_LEN-1:0] SG_LOL    = 23'h000040;
    localparam logic [TABLE_LEN-1:0] SG_UPL    = 23'h000080;
    localparam logic [TABLE_LEN-1:0] SG_MIDL   = 23'h000100;
    localparam logic [TABLE_LEN-1:0] SG_MIDR   = 23'h000200;
    localparam logic [TABLE_LEN-1:0] SG_DUL    = 23'h000400;
    localparam logic [TABLE_LEN-1:0] SG_UPC    = 23'h000800;
    localparam logic [TABLE_LEN-1:0] SG_DUR    = 23'h001000;
    localparam logic [TABLE_LEN-1:0] SG_DLL    = 23'h002000;
    localparam logic [TABLE_LEN-1:0] SG_LOC    = 23'h004000;
    localparam logic [TABLE_LEN-1:0] SG_DLR    = 23'h008000;
    localparam logic [TABLE_LEN-1:0] SG_VLEFT  = 23'h010000;
    localparam logic [TABLE_LEN-1:0] SG_VRIGHT = 23'h020000;
    localparam logic [TABLE_LEN-1:0] SG_DOT    = 23'h040000;
    localparam logic [TABLE_LEN-1:0] SG_TAIL   = 23'h080000;
    localparam logic [TABLE_LEN-1:0] SG_COLU   = 23'h100000;
    localparam logic [TABLE_LEN-1:0] SG_COLL   = 23'h200000;
    localparam logic [TABLE_LEN-1:0] SG_APO    = 23'h400000;

    localparam logic [TABLE_LEN-1:0] SG_TOP = SG_TOPL | SG_TOPR;
    localparam logic [TABLE_LEN-1:0] SG_BOT = SG_BOTL | SG_BOTR;
    localparam logic [TABLE_LEN-1:0] SG_MID = SG_MIDL | SG_MIDR;

    // one glyph waiting to be drawn
    typedef struct packed {
        logic [TABLE_LEN-1:0]       mask;
        logic signed [PEN_X_W-1:0]  pen_x;
        logic signed [COORD_W-1:0]  pen_y;
        logic [SIZE_W-1:0]          size;
    } glyph_job_t;

    // segment endpoints in 1/256-cell units
    typedef struct packed {
        logic [TCOORD_W-1:0] x0;
        logic [TCOORD_W-1:0] y0;
        logic [TCOORD_W-1:0] x1;
        logic [TCOORD_W-1:0] y1;
    } seg_coord_t;

    function automatic seg_coord_t seg_coord(input logic [SEG_IDX_W-1:0] idx);
        seg_coord_t c;
        case (idx)
            5'd0:    c = '{11'd0,   11'd0,    11'd256, 11'd0};
            5'd1:    c = '{11'd256, 11'd0,    11'd512, 11'd0};
            5'd2:    c = '{11'd512, 11'd0,    11'd512, 11'd512};
            5'd3:    c = '{11'd512, 11'd512,  11'd512, 11'd1024};
            5'd4:    c = '{11'd256, 11'd1024, 11'd512, 11'd1024};
            5'd5:    c = '{11'd0,   11'd1024, 11'd256, 11'd1024};
            5'd6:    c = '{11'd0,   11'd512,  11'd0,   11'd1024};
            5'd7:    c = '{11'd0,   11'd0,    11'd0,   11'd512};
            5'd8:    c = '{11'd0,   11'd512,  11'd256, 11'd512};
            5'd9:    c = '{11'd256, 11'd512,  11'd512, 11'd512};
            5'd10:   c = '{11'd0,   11'd0,    11'd256, 11'd512};
            5'd11:   c = '{11'd256, 11'd0,    11'd256, 11'd512};
            5'd12:   c = '{11'd512, 11'd0,    11'd256, 11'd512};
            5'd13:   c = '{11'd0,   11'd1024, 11'd256, 11'd512};
            5'd14:   c = '{11'd256, 11'd512,  11'd256, 11'd1024};
            5'd15:   c = '{11'd512, 11'd1024, 11'd256, 11'd512};
            5'd16:   c = '{11'd0,   11'd0,    11'd256, 11'd1024};
            5'd17:   c = '{11'd512, 11'd0,    11'd256, 11'd1024};
            5'd18:   c = '{11'd256, 11'd896,  11'd256, 11'd1024};
            5'd19:   c = '{11'd294, 11'd896,  11'd192, 11'd1203};
            5'd20:   c = '{11'd256, 11'd230,  11'd256, 11'd384};
            5'd21:   c = '{11'd256, 11'd640,  11'd256, 11'd794};
            5'd22:   c = '{11'd294, 11'd0,    11'd218, 11'd230};
            default: c = '0;
        endcase
        return c;
    endfunction

    function automatic logic [TABLE_LEN-1:0] char_mask(input logic [7:0] code);
        logic [7:0]           ch;
        logic [TABLE_LEN-1:0] m;
        ch = code;
        // fold lower case
        if (ch >= "a" && ch <= "z")
        begin
            ch = ch - 8'h20;
        end
        case (ch)
            "0":     m = SG_TOP | SG_UPR | SG_LOR | SG_BOT | SG_LOL | SG_UPL;
            "1":     m = SG_UPR | SG_LOR;
            "2":     m = SG_TOP | SG_UPR | SG_MID | SG_LOL | SG_BOT;
            "3":     m = SG_TOP | SG_UPR | SG_LOR | SG_BOT | SG_MIDR;
            "4":     m = SG_UPL | SG_MID | SG_UPR | SG_LOR;
            "5":     m = SG_TOP | SG_UPL | SG_MID | SG_LOR | SG_BOT;
            "6":     m = SG_TOP | SG_UPL | SG_LOL | SG_BOT | SG_LOR | SG_MID;
            "7":     m = SG_TOP | SG_UPR | SG_LOR;
            "8":     m = SG_TOP | SG_UPR | SG_LOR | SG_BOT | SG_LOL | SG_UPL | SG_MID;
            "9":     m = SG_TOP | SG_UPR | SG_LOR | SG_BOT | SG_UPL | SG_MID;
            "A":     m = SG_TOP | SG_UPR | SG_LOR | SG_LOL | SG_UPL | SG_MID;
            "B":     m = SG_TOP | SG_UPR | SG_LOR | SG_BOT | SG_MIDR | SG_UPC | SG_LOC;
            "C":     m = SG_TOP | SG_UPL | SG_LOL | SG_BOT;
            "D":     m = SG_TOP | SG_UPR | SG_LOR | SG_BOT | SG_UPC | SG_LOC;
            "E":     m = SG_TOP | SG_UPL | SG_LOL | SG_BOT | SG_MIDL;
            "F":     m = SG_TOP | SG_UPL | SG_LOL | SG_MIDL;
            "G":     m = SG_TOP | SG_UPL | SG_LOL | SG_BOT | SG_LOR | SG_MIDR;
            "H":     m = SG_UPL | SG_LOL | SG_UPR | SG_LOR | SG_MID;
            "I":     m = SG_TOP | SG_BOT | SG_UPC | SG_LOC;
            "J":     m = SG_UPR | SG_LOR | SG_BOT | SG_LOL;
            "K":     m = SG_UPL | SG_LOL | SG_MIDL | SG_DUR | SG_DLR;
            "L":     m = SG_UPL | SG_LOL | SG_BOT;
            "M":     m = SG_UPL | SG_LOL | SG_UPR | SG_LOR | SG_DUL | SG_DUR;
            "N":     m = SG_UPL | SG_LOL | SG_UPR | SG_LOR | SG_DUL | SG_DLR;
            "O":     m = SG_TOP | SG_UPR | SG_LOR | SG_BOT | SG_LOL | SG_UPL;
            "P":     m = SG_TOP | SG_UPR | SG_UPL | SG_LOL | SG_MID;
            "Q":     m = SG_TOP | SG_UPR | SG_LOR | SG_BOT | SG_LOL | SG_UPL | SG_DLR;
            "R":     m = SG_TOP | SG_UPR | SG_UPL | SG_LOL | SG_MID | SG_DLR;
            "S":     m = SG_TOP | SG_UPL | SG_MID | SG_LOR | SG_BOT;
            "T":     m = SG_TOP | SG_UPC | SG_LOC;
            "U":     m = SG_UPL | SG_LOL | SG_BOT | SG_LOR | SG_UPR;
            "V":     m = SG_VLEFT | SG_VRIGHT;
            "W":     m = SG_UPL | SG_LOL | SG_UPR | SG_LOR | SG_DLL | SG_DLR;
            "X":     m = SG_DUL | SG_DUR | SG_DLL | SG_DLR;
            "Y":     m = SG_DUL | SG_DUR | SG_LOC;
            "Z":     m = SG_TOP | SG_DUR | SG_DLL | SG_BOT;
            "-":     m = SG_MID;
            "+":     m = SG_MID | SG_UPC | SG_LOC;
            "/":     m = SG_DUR | SG_DLL;
            ".":     m = SG_DOT;
            ",":     m = SG_TAIL;
            ":":     m = SG_COLU | SG_COLL;
            "'":     m = SG_APO;
            default: m = '0;
        endcase
        return m;
    endfunction

endpackage

@@ rtl/core/sfvg_front.sv @@
`timescale 1ns / 1ps
// front end: takes characters, keeps the pen and size, turns each character into a glyph job
module sfvg_front
    import sfvg_pkg::*;
#(
    parameter int NUM_SEGMENTS = 23
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [7:0]                char_code,
    input  logic                      string_start,
    input  logic signed [COORD_W-1:0] origin_x,
    input  logic signed [COORD_W-1:0] origin_y,
    input  logic [SIZE_W-1:0]         text_size,
    output logic                      push,
    output glyph_job_t                job,
    input  logic                      q_full
);

    localparam logic signed [PEN_X_W:0] PEN_X_MAX = (PEN_X_W+1)'((1 << (PEN_X_W - 1)) - 1);

    logic signed [PEN_X_W-1:0] pen_x_reg, pen_x_next;
    logic signed [COORD_W-1:0] pen_y_reg, pen_y_next;
    logic [SIZE_W-1:0]         size_reg, size_next;

    logic signed [PEN_X_W-1:0] cur_x;
    logic signed [COORD_W-1:0] cur_y;
    logic [SIZE_W-1:0]         cur_size;
    logic [SIZE_W+1:0]         advance;
    logic signed [PEN_X_W:0]   moved_x;
    logic [TABLE_LEN-1:0]      limit;

    // segments at or beyond NUM_SEGMENTS are never drawn
    for (genvar i = 0; i < TABLE_LEN; i++)
    begin : g_limit
        assign limit[i] = (i < NUM_SEGMENTS);
    end

    assign in_ready = !q_full;
    assign push     = in_valid && !q_full;

    always_comb
    begin
        cur_x    = string_start ? {origin_x, 2'b00} : pen_x_reg;
        cur_y    = string_start ? origin_y : pen_y_reg;
        cur_size = string_start ? text_size : size_reg;

        job.mask  = char_mask(char_code) & limit;
        job.pen_x = cur_x;
        job.pen_y = cur_y;
        job.size  = cur_size;

        // pen moves by 3*size in quarter-units of the coordinate format
        advance = {2'b00, cur_size} + {1'b0, cur_size, 1'b0};
        moved_x = {cur_x[PEN_X_W-1], cur_x} + $signed({{(PEN_X_W - SIZE_W - 1){1'b0}}, advance});

        pen_x_next = pen_x_reg;
        pen_y_next = pen_y_reg;
        size_next  = size_reg;
        if (push)
        begin
            pen_y_next = cur_y;
            size_next  = cur_size;
            if (moved_x > PEN_X_MAX)
            begin
                pen_x_next = PEN_X_MAX[PEN_X_W-1:0];
            end
            else
            begin
                pen_x_next = moved_x[PEN_X_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pen_x_reg <= '0;
            pen_y_reg <= '0;
            size_reg  <= '0;
        end
        else
        begin
            pen_x_reg <= pen_x_next;
            pen_y_reg <= pen_y_next;
            size_reg  <= size_next;
        end
    end

endmodule

@@ rtl/core/sfvg_queue.sv @@
`timescale 1ns / 1ps
// two-entry glyph job queue between front and back end
module sfvg_queue
    import sfvg_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  glyph_job_t push_job,
    output logic       full,
    input  logic       pop,
    output glyph_job_t head_job,
    output logic       empty
);

    glyph_job_t mem [2];

    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    assign full     = (count_reg == 2'd2);
    assign empty    = (count_reg == 2'd0);
    assign head_job = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

@@ rtl/core/sfvg_back.sv @@
`timescale 1ns / 1ps
// back end: walks lit glyph segments, scales them, emits one line per cycle unless stalled
module sfvg_back
    import sfvg_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  glyph_job_t                head_job,
    input  logic                      q_empty,
    output logic                      pop,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic signed [COORD_W-1:0] line_x0,
    output logic signed [COORD_W-1:0] line_y0,
    output logic signed [COORD_W-1:0] line_x1,
    output logic signed [COORD_W-1:0] line_y1,
    output logic [SEG_IDX_W-1:0]      segment_number,
    output logic                      last_of_glyph
);

    typedef struct packed {
        logic [PROD_W-1:0]          px0;
        logic [PROD_W-1:0]          py0;
        logic [PROD_W-1:0]          px1;
        logic [PROD_W-1:0]          py1;
        logic signed [PEN_X_W-1:0]  pen_x;
        logic signed [COORD_W-1:0]  pen_y;
        logic [SEG_IDX_W-1:0]       idx;
        logic                       last;
    } prod_stage_t;

    typedef struct packed {
        logic [COORD_W-1:0]   x0;
        logic [COORD_W-1:0]   y0;
        logic [COORD_W-1:0]   x1;
        logic [COORD_W-1:0]   y1;
        logic [SEG_IDX_W-1:0] idx;
        logic                 last;
    } line_t;

    // round to nearest (ties up) after /1024, then saturate to the coordinate range
    function automatic logic [COORD_W-1:0] coord_sat(input logic signed [31:0] base,
                                                     input logic [PROD_W-1:0]  prod);
        logic signed [31:0] sum;
        logic [21:0]        q;
        logic [COORD_W-1:0] r;
        sum = base + $signed({5'b0, prod}) + 32'sd512;
        q   = sum[31:10];
        if (q[21:19] == 3'b000 || q[21:19] == 3'b111)
        begin
            r = q[COORD_W-1:0];
        end
        else if (q[21])
        begin
            r = {1'b1, {(COORD_W-1){1'b0}}};
        end
        else
        begin
            r = {1'b0, {(COORD_W-1){1'b1}}};
        end
        return r;
    endfunction

    logic                 busy_reg, busy_next;
    logic [TABLE_LEN-1:0] rem_reg, rem_next;
    glyph_job_t           job_reg, job_next;
    logic                 s1_valid_reg, s1_valid_next;
    prod_stage_t          s1_reg, s1_next;
    logic                 out_valid_reg, out_valid_next;
    line_t                out_reg, out_next;

    logic                 advance;
    logic                 s1_free;
    logic                 emit;
    logic [SEG_IDX_W-1:0] pick;
    logic [TABLE_LEN-1:0] rem_after;
    seg_coord_t           tc;
    logic signed [31:0]   base_x;
    logic signed [31:0]   base_y;

    assign advance = !out_valid_reg || out_ready;
    assign s1_free = !s1_valid_reg || advance;
    assign emit    = busy_reg && s1_free;
    assign pop     = !busy_reg && !q_empty;

    // lowest lit segment still to draw
    always_comb
    begin
        pick = '0;
        for (int i = TABLE_LEN - 1; i >= 0; i--)
        begin
            if (rem_reg[i])
            begin
                pick = SEG_IDX_W'(i);
            end
        end
    end

    assign rem_after = rem_reg & (rem_reg - 1'b1);
    assign tc        = seg_coord(pick);

    always_comb
    begin
        busy_next = busy_reg;
        rem_next  = rem_reg;
        job_next  = job_reg;
        if (pop)
        begin
            job_next  = head_job;
            rem_next  = head_job.mask;
            busy_next = |head_job.mask;
        end
        else if (emit)
        begin
            rem_next  = rem_after;
            busy_next = |rem_after;
        end

        s1_valid_next = s1_valid_reg;
        s1_next       = s1_reg;
        if (s1_free)
        begin
            s1_valid_next = emit;
        end
        if (emit)
        begin
            s1_next.px0   = PROD_W'(tc.x0) * PROD_W'(job_reg.size);
            s1_next.py0   = PROD_W'(tc.y0) * PROD_W'(job_reg.size);
            s1_next.px1   = PROD_W'(tc.x1) * PROD_W'(job_reg.size);
            s1_next.py1   = PROD_W'(tc.y1) * PROD_W'(job_reg.size);
            s1_next.pen_x = job_reg.pen_x;
            s1_next.pen_y = job_reg.pen_y;
            s1_next.idx   = pick;
            s1_next.last  = ~|rem_after;
        end

        base_x = {{2{s1_reg.pen_x[PEN_X_W-1]}}, s1_reg.pen_x, 8'b0};
        base_y = {{2{s1_reg.pen_y[COORD_W-1]}}, s1_reg.pen_y, 10'b0};

        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (advance)
        begin
            out_valid_next = s1_valid_reg;
            out_next.x0    = coord_sat(base_x, s1_reg.px0);
            out_next.y0    = coord_sat(base_y, s1_reg.py0);
            out_next.x1    = coord_sat(base_x, s1_reg.px1);
            out_next.y1    = coord_sat(base_y, s1_reg.py1);
            out_next.idx   = s1_reg.idx;
            out_next.last  = s1_reg.last;
        end
    end

    always_ff @(posedge clk)
    begin
        job_reg <= job_next;
        s1_reg  <= s1_next;
        out_reg <= out_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            rem_reg       <= '0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            rem_reg       <= rem_next;
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign line_x0        = out_reg.x0;
    assign line_y0        = out_reg.y0;
    assign line_x1        = out_reg.x1;
    assign line_y1        = out_reg.y1;
    assign segment_number = out_reg.idx;
    assign last_of_glyph  = out_reg.last;

endmodule

@@ rtl/core/segment_font_vector_generator_top.sv @@
`timescale 1ns / 1ps
// Vector character generator: each accepted character becomes one line item per lit
// segment of its 23-segment glyph, endpoints scaled by size/4 from the pen and given in
// signed 16.4 pixels; the pen then moves right by 3*size/4. The back end loads each
// glyph from the queue, then emits one line per cycle, while the line output is not held
// off, through a multiply stage and an output register; unmapped characters are loaded
// and give no item. A two-entry glyph queue lets the input run ahead of the line output.
// With the back end idle, the first line of a character passes the glyph queue, the
// glyph load, the multiply stage and the output register before it is presented.
module segment_font_vector_generator_top
    import sfvg_pkg::*;
#(
    parameter int NUM_SEGMENTS = 23
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // char_code[7:0], origin_x[27:8], origin_y[47:28], text_size[63:48]
    input  logic [63:0] s_axis_tdata,
    // string_start[0]
    input  logic        s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // line_x0[19:0], line_y0[39:20], line_x1[59:40], line_y1[79:60],
    // segment_number[84:80], zero[87:85]
    output logic [87:0] m_axis_tdata,
    // last_of_glyph
    output logic        m_axis_tlast
);

    glyph_job_t                push_job;
    glyph_job_t                head_job;
    logic                      push;
    logic                      pop;
    logic                      q_full;
    logic                      q_empty;
    logic signed [COORD_W-1:0] line_x0;
    logic signed [COORD_W-1:0] line_y0;
    logic signed [COORD_W-1:0] line_x1;
    logic signed [COORD_W-1:0] line_y1;
    logic [SEG_IDX_W-1:0]      segment_number;

    sfvg_front #(
        .NUM_SEGMENTS(NUM_SEGMENTS)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (s_axis_tvalid),
        .in_ready     (s_axis_tready),
        .char_code    (s_axis_tdata[7:0]),
        .string_start (s_axis_tuser),
        .origin_x     (s_axis_tdata[27:8]),
        .origin_y     (s_axis_tdata[47:28]),
        .text_size    (s_axis_tdata[63:48]),
        .push         (push),
        .job          (push_job),
        .q_full       (q_full)
    );

    sfvg_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .full     (q_full),
        .pop      (pop),
        .head_job (head_job),
        .empty    (q_empty)
    );

    sfvg_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .head_job       (head_job),
        .q_empty        (q_empty),
        .pop            (pop),
        .out_valid      (m_axis_tvalid),
        .out_ready      (m_axis_tready),
        .line_x0        (line_x0),
        .line_y0        (line_y0),
        .line_x1        (line_x1),
        .line_y1        (line_y1),
        .segment_number (segment_number),
        .last_of_glyph  (m_axis_tlast)
    );

    assign m_axis_tdata = {3'b000, segment_number, line_y1, line_x1, line_y0, line_x0};

endmodule

@@ dv/tb_segment_font_vector_generator_top.sv @@
`timescale 1ns / 1ps
// self-checking testbench for the vector character generator: glyphs, extremes, random text
module tb_segment_font_vector_generator_top
    import sfvg_pkg::*;
();

    localparam int  NUM_LINES     = 23;
    localparam int  RESET_CYCLES  = 11;
    localparam int  LIMIT_CYCLES  = 200000;
    localparam int  DRAIN_CYCLES  = 16;
    localparam int  RANDOM_CHARS  = 85;
    localparam int  REPORT_LIMIT  = 10;
    localparam int  C20_MAX       = 524287;
    localparam int  C20_MIN       = -524288;
    localparam int  PEN_X_MAX     = 2097151;
    localparam int  PEN_X_MIN     = -2097152;
    localparam logic [7:0] CASE_OFFSET = 8'h20;

    // endpoints of each segment in 1/256-cell units: x0, y0, x1, y1
    localparam int SEG_PTS [0:NUM_LINES-1][0:3] = '{
        '{  0,    0, 256,    0}, '{256,    0, 512,    0},
        '{512,    0, 512,  512}, '{512,  512, 512, 1024},
        '{256, 1024, 512, 1024}, '{  0, 1024, 256, 1024},
        '{  0,  512,   0, 1024}, '{  0,    0,   0,  512},
        '{  0,  512, 256,  512}, '{256,  512, 512,  512},
        '{  0,    0, 256,  512}, '{256,    0, 256,  512},
        '{512,    0, 256,  512}, '{  0, 1024, 256,  512},
        '{256,  512, 256, 1024}, '{512, 1024, 256,  512},
        '{  0,    0, 256, 1024}, '{512,    0, 256, 1024},
        '{256,  896, 256, 1024}, '{294,  896, 192, 1203},
        '{256,  230, 256,  384}, '{256,  640, 256,  794},
        '{294,    0, 218,  230}
    };

    typedef struct packed {
        logic signed [COORD_W-1:0] x0;
        logic signed [COORD_W-1:0] y0;
        logic signed [COORD_W-1:0] x1;
        logic signed [COORD_W-1:0] y1;
        logic [SEG_IDX_W-1:0]      seg;
        logic                      last;
    } line_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata;
    logic        s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [87:0] m_axis_tdata;
    logic        m_axis_tlast;

    line_t  expected_lines[$];
    line_t  got_line;
    line_t  want_line;
    longint pen_x;
    longint pen_y;
    longint cur_size;
    int     errors;
    int     chars_sent;
    int     lines_checked;
    int     cycle_count;
    int     stall_left;
    bit     line_taken;
    bit     no_idle;
    string  glyph_pool = "0123456789ABCDEFGHIJKLMNOPQRSTUVWXYZ-+/.,:'";

    segment_font_vector_generator_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #6 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("timeout after %0d cycles, %0d lines still pending",
                     cycle_count, expected_lines.size());
            $display("Some tests failed");
            $finish;
        end
    end

    function automatic logic [TABLE_LEN-1:0] char_segments(input logic [7:0] code);
        logic [7:0] ch;
        ch = code;
        if (ch >= "a" && ch <= "z")
        begin
            ch = ch - CASE_OFFSET;
        end
        case (ch)
            "0", "O": return SG_TOP | SG_UPR | SG_LOR | SG_BOT | SG_LOL | SG_UPL;
            "1":      return SG_UPR | SG_LOR;
            "2":      return SG_TOP | SG_UPR | SG_MID | SG_LOL | SG_BOT;
            "3":      return SG_TOP | SG_UPR | SG_LOR | SG_BOT | SG_MIDR;
            "4":      return SG_UPL | SG_MID | SG_UPR | SG_LOR;
            "5", "S": return SG_TOP | SG_UPL | SG_MID | SG_LOR | SG_BOT;
            "6":      return SG_TOP | SG_UPL | SG_LOL | SG_BOT | SG_LOR | SG_MID;
            "7":      return SG_TOP | SG_UPR | SG_LOR;
            "8":      return SG_TOP | SG_UPR | SG_LOR | SG_BOT | SG_LOL | SG_UPL | SG_MID;
            "9":      return SG_TOP | SG_UPR | SG_LOR | SG_BOT | SG_UPL | SG_MID;
            "A":      return SG_TOP | SG_UPR | SG_LOR | SG_LOL | SG_UPL | SG_MID;
            "B":      return SG_TOP | SG_UPR | SG_LOR | SG_BOT | SG_MIDR | SG_UPC | SG_LOC;
            "C":      return SG_TOP | SG_UPL | SG_LOL | SG_BOT;
            "D":      return SG_TOP | SG_UPR | SG_LOR | SG_BOT | SG_UPC | SG_LOC;
            "E":      return SG_TOP | SG_UPL | SG_LOL | SG_BOT | SG_MIDL;
            "F":      return SG_TOP | SG_UPL | SG_LOL | SG_MIDL;
            "G":      return SG_TOP | SG_UPL | SG_LOL | SG_BOT | SG_LOR | SG_MIDR;
            "H":      return SG_UPL | SG_LOL | SG_UPR | SG_LOR | SG_MID;
            "I":      return SG_TOP | SG_BOT | SG_UPC | SG_LOC;
            "J":      return SG_UPR | SG_LOR | SG_BOT | SG_LOL;
            "K":      return SG_UPL | SG_LOL | SG_MIDL | SG_DUR | SG_DLR;
            "L":      return SG_UPL | SG_LOL | SG_BOT;
            "M":      return SG_UPL | SG_LOL | SG_UPR | SG_LOR | SG_DUL | SG_DUR;
            "N":      return SG_UPL | SG_LOL | SG_UPR | SG_LOR | SG_DUL | SG_DLR;
            "P":      return SG_TOP | SG_UPR | SG_UPL | SG_LOL | SG_MID;
            "Q":      return SG_TOP | SG_UPR | SG_LOR | SG_BOT | SG_LOL | SG_UPL | SG_DLR;
            "R":      return SG_TOP | SG_UPR | SG_UPL | SG_LOL | SG_MID | SG_DLR;
            "T":      return SG_TOP | SG_UPC | SG_LOC;
            "U":      return SG_UPL | SG_LOL | SG_BOT | SG_LOR | SG_UPR;
            "V":      return SG_VLEFT | SG_VRIGHT;
            "W":      return SG_UPL | SG_LOL | SG_UPR | SG_LOR | SG_DLL | SG_DLR;
            "X":      return SG_DUL | SG_DUR | SG_DLL | SG_DLR;
            "Y":      return SG_DUL | SG_DUR | SG_LOC;
            "Z":      return SG_TOP | SG_DUR | SG_DLL | SG_BOT;
            "-":      return SG_MID;
            "+":      return SG_MID | SG_UPC | SG_LOC;
            "/":      return SG_DUR | SG_DLL;
            ".":      return SG_DOT;
            ",":      return SG_TAIL;
            ":":      return SG_COLU | SG_COLL;
            "'":      return SG_APO;
            default:  return '0;
        endcase
    endfunction

    // divide by 1024 rounding half up, then saturate to the output range
    function automatic logic signed [COORD_W-1:0] scale_coord(input longint num);
        longint q;
        q = (num + 512) >>> 10;
        if (q > C20_MAX)
        begin
            q = C20_MAX;
        end
        else if (q < C20_MIN)
        begin
            q = C20_MIN;
        end
        return q[COORD_W-1:0];
    endfunction

    task automatic predict_glyph_lines(input logic [7:0] code, input logic start,
                                       input logic signed [COORD_W-1:0] ox,
                                       input logic signed [COORD_W-1:0] oy,
                                       input logic [SIZE_W-1:0] sz);
        logic [TABLE_LEN-1:0] mask;
        line_t                ln;
        int                   last_seg;
        if (start)
        begin
            pen_x    = longint'(ox) * 4;
            pen_y    = longint'(oy);
            cur_size = longint'(sz);
        end
        mask     = char_segments(code);
        last_seg = -1;
        for (int s = 0; s < NUM_LINES; s++)
        begin
            if (mask[s])
            begin
                last_seg = s;
            end
        end
        for (int s = 0; s < NUM_LINES; s++)
        begin
            if (mask[s])
            begin
                ln.x0   = scale_coord(pen_x * 256 + SEG_PTS[s][0] * cur_size);
                ln.y0   = scale_coord(pen_y * 1024 + SEG_PTS[s][1] * cur_size);
                ln.x1   = scale_coord(pen_x * 256 + SEG_PTS[s][2] * cur_size);
                ln.y1   = scale_coord(pen_y * 1024 + SEG_PTS[s][3] * cur_size);
                ln.seg  = s[SEG_IDX_W-1:0];
                ln.last = (s == last_seg);
                expected_lines.push_back(ln);
            end
        end
        // pen moves by 3*size/4 pixels, exactly 3*size in quarter-lsb units
        pen_x = pen_x + 3 * cur_size;
        if (pen_x > PEN_X_MAX)
        begin
            pen_x = PEN_X_MAX;
        end
        else if (pen_x < PEN_X_MIN)
        begin
            pen_x = PEN_X_MIN;
        end
    endtask

    // entered and left at a falling edge
    task automatic send_char(input logic [7:0] code, input logic start,
                             input logic [COORD_W-1:0] ox, input logic [COORD_W-1:0] oy,
                             input logic [SIZE_W-1:0] sz);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 3);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= start;
        s_axis_tdata  <= {sz, oy, ox, code};
        do
            @(posedge clk);
        while (!s_axis_tready);
        predict_glyph_lines(code, start, ox, oy, sz);
        chars_sent++;
        @(negedge clk);
    endtask

    // line receiver: random stall before each item, none in no-idle stretches
    always @(negedge clk)
    begin
        if (line_taken)
        begin
            line_taken = 1'b0;
            stall_left = no_idle ? 0 : $urandom_range(0, 3);
        end
        if (stall_left > 0)
        begin
            m_axis_tready <= 1'b0;
            stall_left--;
        end
        else
        begin
            m_axis_tready <= 1'b1;
        end
    end

    task automatic report_line(input string what, input line_t want, input line_t got);
        errors++;
        if (errors <= REPORT_LIMIT)
        begin
            $display("%s at %0t: expected (%0d,%0d)-(%0d,%0d) seg %0d last %0b,",
                     what, $time, want.x0, want.y0, want.x1, want.y1, want.seg, want.last);
            $display("    got (%0d,%0d)-(%0d,%0d) seg %0d last %0b",
                     got.x0, got.y0, got.x1, got.y1, got.seg, got.last);
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            line_taken    = 1'b1;
            got_line.x0   = m_axis_tdata[19:0];
            got_line.y0   = m_axis_tdata[39:20];
            got_line.x1   = m_axis_tdata[59:40];
            got_line.y1   = m_axis_tdata[79:60];
            got_line.seg  = m_axis_tdata[84:80];
            got_line.last = m_axis_tlast;
            lines_checked++;
            if (expected_lines.size() == 0)
            begin
                report_line("unexpected line", '0, got_line);
            end
            else
            begin
                want_line = expected_lines.pop_front();
                if (got_line.x0 !== want_line.x0 || got_line.y0 !== want_line.y0 ||
                    got_line.x1 !== want_line.x1 || got_line.y1 !== want_line.y1 ||
                    got_line.seg !== want_line.seg || got_line.last !== want_line.last)
                begin
                    report_line("line mismatch", want_line, got_line);
                end
            end
        end
    end

    // characters before any string start use the cleared pen and zero size
    task automatic test_reset_pen;
        send_char("8", 1'b0, 20'h12345, 20'h54321, 16'h1234);
        send_char("w", 1'b0, 20'hFFFFF, 20'h00000, 16'hFFFF);
    endtask

    task automatic test_glyph_shapes;
        send_char("B", 1'b1, 20'h00640, 20'h00320, 16'h0100);
        send_char("q", 1'b0, 20'h0, 20'h0, 16'h0);
        send_char(",", 1'b0, 20'h0, 20'h0, 16'h0);
        send_char("'", 1'b0, 20'h0, 20'h0, 16'h0);
        send_char(":", 1'b0, 20'h0, 20'h0, 16'h0);
        send_char(".", 1'b0, 20'h0, 20'h0, 16'h0);
        send_char("/", 1'b0, 20'h0, 20'h0, 16'h0);
        send_char("V", 1'b0, 20'h0, 20'h0, 16'h0);
        // unmapped codes draw nothing but still move the pen
        send_char(" ", 1'b0, 20'h0, 20'h0, 16'h0);
        send_char(8'h7F, 1'b0, 20'h0, 20'h0, 16'h0);
        send_char(8'hC1, 1'b0, 20'h0, 20'h0, 16'h0);
        send_char(8'h00, 1'b0, 20'h0, 20'h0, 16'h0);
        send_char("m", 1'b0, 20'h0, 20'h0, 16'h0);
        send_char("z", 1'b0, 20'h0, 20'h0, 16'h0);
    endtask

    task automatic test_extremes;
        send_char("8", 1'b1, 20'h7FFFF, 20'h7FFFF, 16'hFFFF);
        send_char("8", 1'b0, 20'h0, 20'h0, 16'h0);
        send_char("x", 1'b1, 20'h80000, 20'h80000, 16'hFFFF);
        send_char("+", 1'b1, 20'h80000, 20'h00000, 16'h0000);
        send_char(",", 1'b1, 20'h00000, 20'h00000, 16'h0001);
        send_char("'", 1'b0, 20'h0, 20'h0, 16'h0);
        send_char("W", 1'b1, 20'h12345, 20'hFEDCB, 16'h8001);
    endtask

    function automatic logic [7:0] pick_char();
        logic [7:0] ch;
        if ($urandom_range(0, 4) == 0)
        begin
            return 8'($urandom_range(0, 255));
        end
        ch = glyph_pool[$urandom_range(0, glyph_pool.len() - 1)];
        if (ch >= "A" && ch <= "Z" && $urandom_range(0, 1) == 1)
        begin
            ch = ch + CASE_OFFSET;
        end
        return ch;
    endfunction

    task automatic test_random_strings;
        int            target;
        int            len;
        logic          start;
        logic [SIZE_W-1:0] sz;
        target = chars_sent + RANDOM_CHARS;
        while (chars_sent < target)
        begin
            no_idle = ($urandom_range(0, 4) == 0);
            len     = $urandom_range(1, 10);
            // now and then a string carries on from the previous pen
            start   = ($urandom_range(0, 7) != 0);
            sz      = ($urandom_range(0, 4) == 0) ? SIZE_W'($urandom_range(0, 65535))
                                                  : SIZE_W'($urandom_range(0, 1023));
            for (int k = 0; k < len; k++)
            begin
                send_char(pick_char(), (k == 0) ? start : 1'b0,
                          COORD_W'($urandom_range(0, 20'hFFFFF)),
                          COORD_W'($urandom_range(0, 20'hFFFFF)),
                          (k == 0) ? sz : SIZE_W'($urandom_range(0, 65535)));
            end
        end
        no_idle = 1'b0;
    endtask

    initial
    begin
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = 1'b0;
        m_axis_tready = 1'b0;
        errors        = 0;
        chars_sent    = 0;
        lines_checked = 0;
        cycle_count   = 0;
        stall_left    = 0;
        line_taken    = 1'b0;
        no_idle       = 1'b0;
        pen_x         = 0;
        pen_y         = 0;
        cur_size      = 0;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_reset_pen();
        test_glyph_shapes();
        test_extremes();
        test_random_strings();
        s_axis_tvalid <= 1'b0;

        while (expected_lines.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("%0d characters sent (directed glyphs, extremes, random strings),",
                 chars_sent);
        $display("%0d lines checked, %0d errors over %0d cycles",
                 lines_checked, errors, cycle_count);
        if (errors == 0)
        begin
            $display("All tests passed");
        end
        else
        begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
